/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define LME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define LME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/lme_pkg.sv */
package lme_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned PixCountW = 25;
  localparam int unsigned PixIdxW   = 24;
  localparam logic [7:0]  DelimChar = 8'h23;
  localparam logic [PixCountW-1:0] MaxPixels = 25'd16777216;

  // Each pixel yields at most one completed byte plus a two-entry flush.
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResCntW    = 2;

  // Result queue: depth is a power of two so that pointers wrap by themselves.
  localparam int unsigned PtrW     = 2;
  localparam int unsigned ResDepth = 1 << PtrW;

  typedef struct packed {
    logic       delim;
    logic       eom;
    logic       has;
    logic [7:0] data;
  } res_t;

endpackage

/* hdl/lme_core.sv */
module lme_core
  import lme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [2:0]            rgb_bits,
  input  logic [PixIdxW-1:0]    last_pix,
  output res_t [MaxResults-1:0] res,
  output logic [ResCntW-1:0]    res_cnt
);

  logic [7:0]         acc_r, acc_nxt;
  logic [2:0]         bits_r, bits_nxt;
  logic [7:0]         h0_r, h0_nxt;
  logic [7:0]         h1_r, h1_nxt;
  logic [1:0]         hcnt_r, hcnt_nxt;
  logic [PixIdxW-1:0] pix_r, pix_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    logic [7:0]         byte_v;
    logic [ResCntW-1:0] n;
    acc_nxt  = acc_r;
    bits_nxt = bits_r;
    h0_nxt   = h0_r;
    h1_nxt   = h1_r;
    hcnt_nxt = hcnt_r;
    done_nxt = done_r;
    pix_nxt  = pix_r;
    byte_v   = '0;
    n        = '0;
    res      = '0;

    // Red, green, blue in turn; a byte completes at most once per pixel.
    for (int c = 0; c < 3; c++) begin
      if (!done_nxt) begin
        acc_nxt = {acc_nxt[6:0], rgb_bits[2-c]};
        if (bits_nxt == 3'd7) begin
          byte_v   = acc_nxt;
          bits_nxt = '0;
          acc_nxt  = '0;
          if (hcnt_nxt[1]) begin
            if (h0_nxt == DelimChar && h1_nxt == DelimChar && byte_v == DelimChar) begin
              res[n].eom   = 1'b1;
              res[n].delim = 1'b1;
              n            = n + 1'b1;
              hcnt_nxt     = '0;
              h0_nxt       = '0;
              h1_nxt       = '0;
              done_nxt     = 1'b1;
            end else begin
              res[n].data = h0_nxt;
              res[n].has  = 1'b1;
              n           = n + 1'b1;
              h0_nxt      = h1_nxt;
              h1_nxt      = byte_v;
            end
          end else begin
            if (hcnt_nxt[0]) begin
              h1_nxt = byte_v;
            end else begin
              h0_nxt = byte_v;
            end
            hcnt_nxt = hcnt_nxt + 1'b1;
          end
        end else begin
          bits_nxt = bits_nxt + 1'b1;
        end
      end
    end

    // Last pixel of the image: flush what is held, then rearm.
    if (pix_r >= last_pix) begin
      if (!done_nxt) begin
        case (hcnt_nxt)
          2'd0: begin
            res[n].eom = 1'b1;
            n          = n + 1'b1;
          end
          2'd1: begin
            res[n].data = h0_nxt;
            res[n].has  = 1'b1;
            res[n].eom  = 1'b1;
            n           = n + 1'b1;
          end
          default: begin
            res[n].data = h0_nxt;
            res[n].has  = 1'b1;
            n           = n + 1'b1;
            res[n].data = h1_nxt;
            res[n].has  = 1'b1;
            res[n].eom  = 1'b1;
            n           = n + 1'b1;
          end
        endcase
      end
      acc_nxt  = '0;
      bits_nxt = '0;
      h0_nxt   = '0;
      h1_nxt   = '0;
      hcnt_nxt = '0;
      done_nxt = 1'b0;
      pix_nxt  = '0;
    end else begin
      pix_nxt = pix_r + 1'b1;
    end
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      bits_r <= '0;
      h0_r   <= '0;
      h1_r   <= '0;
      hcnt_r <= '0;
      pix_r  <= '0;
      done_r <= 1'b0;
    end else if (take) begin
      acc_r  <= acc_nxt;
      bits_r <= bits_nxt;
      h0_r   <= h0_nxt;
      h1_r   <= h1_nxt;
      hcnt_r <= hcnt_nxt;
      pix_r  <= pix_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

/* hdl/lsb_message_extract_unit.sv */
// Extracts a hidden message from the least significant bits of an RGB pixel
// stream: bit 0 of red, green and blue, in that order, builds bytes MSB first.
// The two most recent bytes are held back so that a "###" delimiter can be
// removed; the delimiter ends the message with a bare result that has
// delimiter_found set, and the remaining pixels of the image give nothing.
// After cfg pixel_count pixels (0 counts as 1, values above 2^24 as 2^24) the
// held bytes are flushed, the last one marked, and the next image starts.
// A pixel is taken every clock while results drain at one per clock; each
// pixel is decoded in the cycle it is accepted and its results are written
// to a four-entry result queue whose registered entries drive the output.
// Input is taken only while the queue holds at most one result, leaving
// room for three, so with the receiver ready a pixel that ends an image
// with two or three results pauses the input until the queue drains to one.
module lsb_message_extract_unit
  import lme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // red_value, green_value, blue_value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // message_byte
  output logic [1:0]           out_tuser,  // has_byte, delimiter_found
  output logic                 out_tlast,  // end_of_message
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PixCountW-1:0] cfg_data    // pixel_count
);

  logic [PixIdxW-1:0]    last_r;
  logic                  take;
  res_t [MaxResults-1:0] res;
  logic [ResCntW-1:0]    res_cnt;

  res_t              fifo_r [ResDepth];
  logic [PtrW-1:0]   wr_r, rd_r;
  logic [PtrW:0]     cnt_r;
  logic [ResCntW-1:0] push_n;
  logic              pop;

  assign cfg_ready = 1'b1;

  // Store the index of the last pixel of an image rather than the count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_data == '0) begin
        last_r <= '0;
      end else if (cfg_data > MaxPixels) begin
        last_r <= '1;
      end else begin
        last_r <= PixIdxW'(cfg_data - 1'b1);
      end
    end
  end

  assign in_tready = (cnt_r <= (PtrW+1)'(ResDepth - MaxResults));
  assign take      = in_tvalid & in_tready;

  lme_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rgb_bits ({in_tdata[0], in_tdata[8], in_tdata[16]}),
    .last_pix (last_r),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  assign push_n     = take ? res_cnt : '0;
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (ResCntW'(i) < push_n) begin
        fifo_r[wr_r + PtrW'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PtrW'(push_n);
      rd_r  <= rd_r + PtrW'(pop);
      cnt_r <= cnt_r + (PtrW+1)'(push_n) - (PtrW+1)'(pop);
    end
  end

  assign out_tdata = fifo_r[rd_r].data;
  assign out_tuser = {fifo_r[rd_r].delim, fifo_r[rd_r].has};
  assign out_tlast = fifo_r[rd_r].eom;

endmodule

/* hdl/lme_checker.sv */
`include "assert_macros.svh"

module lme_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  logic has_byte;
  logic delim_found;

  assign has_byte    = out_tuser[0];
  assign delim_found = out_tuser[1];

  `LME_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `LME_ASSERT(a_bare_end, out_tvalid && !has_byte |-> out_tlast && out_tdata == '0, "bad end marker")
  `LME_ASSERT(a_delim_end, out_tvalid && delim_found |-> out_tlast && !has_byte, "delimiter on data")
  `LME_ASSERT(a_backlog, !in_tready |-> out_tvalid, "input stalled with no pending result")
  `LME_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result pending right after reset")

endmodule

bind lsb_message_extract_unit lme_checker u_lme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/lsb_message_extract_unit_tb.sv */
`timescale 1ns / 1ps

module lsb_message_extract_unit_tb;
  import lme_pkg::*;

  localparam int FillZero     = 0;
  localparam int FillOnes     = 1;
  localparam int FillRand     = 2;
  localparam int SettleCycles = 10;
  localparam int HoldCycles   = 300;
  localparam int RandomPixels = 400;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata   = '0;   // red_value, green_value, blue_value
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // message_byte
  logic [1:0]           out_tuser;         // has_byte, delimiter_found
  logic                 out_tlast;         // end_of_message
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [PixCountW-1:0] cfg_data   = '0;   // pixel_count

  lsb_message_extract_unit dut (.*);

  always #2 clk = ~clk;

  // Shadow of the decoder state.
  logic [PixCountW-1:0] pix_limit;
  logic [7:0]           lsb_acc;
  int                   lsb_count;
  logic [7:0]           held [2];
  int                   held_n;
  int unsigned          pix_seen;
  bit                   msg_done;

  res_t        decoded_results[$];
  logic [23:0] pixel_feed[$];
  bit          lsb_bits[$];

  int mismatches   = 0;
  int n_pixels     = 0;
  int n_results    = 0;
  int n_delims     = 0;
  int n_cfg        = 0;
  int pix_queued   = 0;
  bit pix_fired    = 1'b0;
  int tx_gap       = 0;
  int rx_stall     = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;
  bit hold_taken   = 1'b0;
  int tx_mode      = 0;
  int rx_mode      = 0;

  function automatic void clear_image();
    lsb_acc   = '0;
    lsb_count = 0;
    held[0]   = '0;
    held[1]   = '0;
    held_n    = 0;
    pix_seen  = 0;
    msg_done  = 1'b0;
  endfunction

  function automatic void push_result(logic [7:0] b, logic has, logic eom, logic dl);
    res_t r;
    r.data  = b;
    r.has   = has;
    r.eom   = eom;
    r.delim = dl;
    decoded_results.push_back(r);
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (held_n == 2) begin
      if (held[0] == DelimChar && held[1] == DelimChar && b == DelimChar) begin
        push_result(8'h00, 1'b0, 1'b1, 1'b1);
        held_n   = 0;
        held[0]  = '0;
        held[1]  = '0;
        msg_done = 1'b1;
      end else begin
        push_result(held[0], 1'b1, 1'b0, 1'b0);
        held[0] = held[1];
        held[1] = b;
      end
    end else begin
      held[held_n[0]] = b;
      held_n++;
    end
  endfunction

  function automatic void decode_pixel(logic [23:0] px);
    int unsigned lim;
    int          c;
    lim = 32'(pix_limit);
    if (lim == 0) lim = 1;
    if (lim > MaxPixels) lim = 32'(MaxPixels);
    for (c = 0; c < 3; c++) begin
      if (!msg_done) begin
        lsb_acc = {lsb_acc[6:0], px[8*c]};
        lsb_count++;
        if (lsb_count == 8) begin
          lsb_count = 0;
          take_byte(lsb_acc);
          lsb_acc = '0;
        end
      end
    end
    if (pix_seen + 1 >= lim) begin
      if (!msg_done) begin
        case (held_n)
          0: begin
            push_result(8'h00, 1'b0, 1'b1, 1'b0);
          end
          1: begin
            push_result(held[0], 1'b1, 1'b1, 1'b0);
          end
          default: begin
            push_result(held[0], 1'b1, 1'b0, 1'b0);
            push_result(held[1], 1'b1, 1'b1, 1'b0);
          end
        endcase
      end
      clear_image();
    end else begin
      pix_seen++;
    end
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] pick_msg_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return DelimChar;
    if (r < 38) return 8'h00;
    if (r < 44) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    int i;
    for (i = 7; i >= 0; i--) lsb_bits.push_back(b[i]);
  endtask

  // Spreads the pending message bits over npix pixels; missing bits are random.
  task automatic queue_pixels(input int npix, input int fill);
    logic [23:0] px;
    logic [6:0]  upper;
    bit          lsb;
    int          p;
    int          c;
    for (p = 0; p < npix; p++) begin
      for (c = 0; c < 3; c++) begin
        if (fill == FillZero) upper = '0;
        else if (fill == FillOnes) upper = '1;
        else upper = 7'($urandom);
        if (lsb_bits.size() != 0) lsb = lsb_bits.pop_front();
        else lsb = 1'($urandom);
        px[8*c +: 8] = {upper, lsb};
      end
      pixel_feed.push_back(px);
    end
    lsb_bits.delete();
    pix_queued += npix;
  endtask

  // A message of random length, often with a delimiter somewhere in it.
  task automatic queue_message_image(input int npix);
    int nb;
    int mark;
    int i;
    nb = $urandom_range(0, (3 * npix) / 8 + 1);
    mark = -1;
    if ($urandom_range(0, 9) < 6) mark = $urandom_range(0, nb);
    for (i = 0; i <= nb; i++) begin
      if (i == mark) repeat (3) add_byte(DelimChar);
      if (i < nb) add_byte(pick_msg_byte());
    end
    queue_pixels(npix, FillRand);
  endtask

  task automatic write_pixel_count(input logic [PixCountW-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // A pixel may leave no result behind, so wait on past the last one as well.
  task automatic wait_idle();
    while (pixel_feed.size() != 0 || in_tvalid || decoded_results.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      pix_limit = PixCountW'(1);
      clear_image();
      pix_fired = 1'b0;
    end else begin
      pix_fired = in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) pix_limit = cfg_data;
      if (pix_fired) begin
        decode_pixel(in_tdata);
        n_pixels++;
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (out_tuser[1]) n_delims++;
        if (decoded_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %02h has %0b eom %0b delim %0b",
                     out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
        end else begin
          want = decoded_results.pop_front();
          if (out_tdata !== want.data || out_tuser[0] !== want.has ||
              out_tlast !== want.eom || out_tuser[1] !== want.delim) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected byte %02h has %0b eom %0b delim %0b,",
                       want.data, want.has, want.eom, want.delim,
                       " got byte %02h has %0b eom %0b delim %0b",
                       out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
          end
        end
      end
    end
  end

  // A request stays up until taken; gaps only fall between requests.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (in_tvalid && !pix_fired) begin
    end else if (tx_gap > 0) begin
      in_tvalid <= 1'b0;
      tx_gap--;
    end else if (pixel_feed.size() != 0) begin
      in_tdata  <= pixel_feed.pop_front();
      in_tvalid <= 1'b1;
      tx_gap = pick_gap(tx_mode);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall  = 0;
      hold_left = 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_stall = pick_gap(rx_mode);
    end
  end

  initial begin
    int phase;
    int lim;
    int i;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Zero size counts as one pixel: each pixel ends an image with no byte held.
    write_pixel_count('0);
    repeat (3) lsb_bits.push_back(1'b0);
    queue_pixels(1, FillZero);
    repeat (3) lsb_bits.push_back(1'b1);
    queue_pixels(1, FillOnes);
    wait_idle();

    // Third byte completes on the last pixel, then both held bytes flush.
    write_pixel_count(25'd8);
    add_byte("A");
    add_byte("B");
    add_byte("C");
    queue_pixels(8, FillOnes);
    wait_idle();

    // Delimiter ends inside a pixel; the rest of the image stays silent.
    write_pixel_count(25'd16);
    add_byte("X");
    repeat (3) add_byte(DelimChar);
    queue_pixels(16, FillZero);
    wait_idle();

    // Oversized and largest sizes leave an image open; a small size then closes it.
    write_pixel_count('1);
    queue_message_image(20);
    wait_idle();
    write_pixel_count(MaxPixels);
    queue_message_image(20);
    wait_idle();

    phase = 0;
    while (pix_queued < RandomPixels || phase <= 3) begin
      if ($urandom_range(0, 4) == 0) lim = $urandom_range(13, 40);
      else lim = $urandom_range(1, 12);
      tx_mode = int'($urandom_range(0, 2) != 0);
      rx_mode = int'($urandom_range(0, 2) != 0);
      if (phase == 3) begin
        lim      = 10;
        tx_mode  = 0;
        hold_req = 1'b1;
      end
      write_pixel_count(lim[PixCountW-1:0]);
      for (i = 0; i < ((phase == 3) ? 4 : $urandom_range(1, 4)); i++) begin
        if ($urandom_range(0, 6) == 0) queue_pixels(lim, FillRand);
        else queue_message_image(lim);
      end
      wait_idle();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (decoded_results.size() != 0) begin
      $display("%0d decoded results never came out", decoded_results.size());
      mismatches += decoded_results.size();
    end
    $display("Run covered %0d pixels over %0d size settings, from zero to beyond the maximum.",
             n_pixels, n_cfg);
    $display("It checked %0d results, %0d of them delimiter ends, with %0d mismatches.",
             n_results, n_delims, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Run timed out with %0d results outstanding", decoded_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
